[rtl/core/periodic_timer_table_defines.svh]
// Assertion macros for the checker file.
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

// Assert that an implication holds at every clock edge out of reset.
`define PTT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition holds at every clock edge, reset included.
`define PTT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ptt_pkg.sv]
`timescale 1ns / 1ps
package ptt_pkg;
  localparam int unsigned Timers   = 16;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned IdBits   = 32;
  localparam int unsigned IdxBits  = $clog2(Timers);
  localparam int unsigned CntBits  = $clog2(Timers + 1);
  localparam int unsigned QDepth   = 2;

  localparam logic [TimeBits-1:0] Never   = {TimeBits{1'b1}};
  localparam logic [47:0]         WaitMax = {1'b0, {47{1'b1}}};

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_REM_ALL = 3'd2,
    CMD_SET_EN  = 3'd3,
    CMD_SET_IV  = 3'd4,
    CMD_DISPATCH= 3'd5,
    CMD_POLL    = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_REMOVED = 3'd2,
    KIND_FIRED   = 3'd3,
    KIND_ACK     = 3'd4,
    KIND_TIMEOUT = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] target_id;
    logic [47:0] interval;
    logic        enable;
    logic [47:0] now_time;
    logic [47:0] wait_limit;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_id;
    logic [47:0] wait_ticks;
    logic        last;
  } res_t;

  // Saturating deadline sum, held below the never value.
  function automatic logic [TimeBits-1:0] sat_deadline(logic [TimeBits-1:0] now,
                                                       logic [TimeBits-1:0] iv);
    logic [TimeBits:0] s;
    s = {1'b0, now} + {1'b0, iv};
    if (s >= {1'b0, Never}) begin
      sat_deadline = Never - 1'b1;
    end else begin
      sat_deadline = s[TimeBits-1:0];
    end
  endfunction
endpackage

[rtl/core/ptt_stream_if.sv]
`timescale 1ns / 1ps
interface ptt_cmd_if import ptt_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptt_res_if import ptt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/ptt_front.sv]
`timescale 1ns / 1ps
module ptt_front import ptt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptt_cmd_if.sink    cmd_in,
  output logic       q_valid_o,
  output cmd_t       q_data_o,
  input  logic       q_pop_i
);
  cmd_t                   mem_q [QDepth];
  logic [$clog2(QDepth):0] cnt_q, cnt_d;
  logic [$clog2(QDepth)-1:0] rd_q, wr_q;
  logic push;
  cmd_t cls;

  // Classify: wait_limit is cleared for every command but poll; the command passes unchanged.
  always_comb begin
    cls = cmd_in.data;
    cls.command = cmd_in.data.command;
    if (cls.command != CMD_POLL) begin
      cls.wait_limit = '0;
    end
  end

  assign cmd_in.ready = (cnt_q != QDepth[$clog2(QDepth):0]);
  assign push = cmd_in.valid && cmd_in.ready;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, q_pop_i};
  end

  // Short queue towards the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
      wr_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end
endmodule

[rtl/core/ptt_back.sv]
`timescale 1ns / 1ps
module ptt_back import ptt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  cmd_t     q_data_i,
  output logic     q_pop_o,
  ptt_res_if.source res_out
);
  logic [IdBits-1:0]   id_q   [Timers];
  logic [TimeBits-1:0] iv_q   [Timers];
  logic [TimeBits-1:0] dl_q   [Timers];
  logic [Timers-1:0]   taken_q;
  logic [CntBits-1:0]  count_q;
  logic [IdBits-1:0]   idc_q;

  state_e state_q, state_d;
  cmd_t   cur_q;
  logic [IdxBits-1:0]  i_q;
  logic [CntBits-1:0]  emitted_q;
  logic [CntBits-1:0]  total_q;
  logic                best_ok_q;
  logic [IdxBits-1:0]  best_q;
  logic [IdxBits-1:0]  fidx_q;
  logic [TimeBits-1:0] min_q;
  kind_e               rs_kind_q;
  logic [IdBits-1:0]   rs_id_q;

  logic        ov_q;
  res_t        od_q;
  logic        out_free;
  logic        emit_now;
  logic        last_i;
  logic        has_room;
  logic        match;
  logic        final_emit;
  logic        due, better, cand;
  logic [TimeBits-1:0] now;
  logic [IdBits-1:0]   nid;
  logic [TimeBits:0]   nw_sum;
  logic [TimeBits-1:0] poll_res;
  logic [TimeBits-1:0] diff;

  assign now = cur_q.now_time;
  assign out_free = !ov_q || res_out.ready;
  assign emit_now = out_free && ((state_q == ST_EMIT) || (state_q == ST_DONE));
  assign res_out.valid = ov_q;
  assign res_out.data = od_q;
  assign last_i = ({1'b0, i_q} == count_q - 1'b1);
  assign has_room = (count_q < Timers[CntBits-1:0]);
  assign match = (id_q[i_q] == cur_q.target_id) && (cur_q.command != CMD_POLL);
  assign final_emit = (emitted_q + 1'b1 == total_q);
  assign nid = (idc_q + 1'b1 == '0) ? {{(IdBits-1){1'b0}}, 1'b1} : idc_q + 1'b1;

  // Candidate test of the scan at entry i.
  always_comb begin
    due = (dl_q[i_q] != Never) && (dl_q[i_q] <= now);
    cand = !taken_q[i_q] && ((cur_q.command != CMD_DISPATCH) || due);
    if (cur_q.command == CMD_REM_ALL) begin
      better = !best_ok_q || (dl_q[i_q] >= dl_q[best_q]);
    end else begin
      better = !best_ok_q || (dl_q[i_q] < dl_q[best_q]);
    end
  end

  // Poll answer from the smallest deadline.
  always_comb begin
    nw_sum = {1'b0, now} + {1'b0, cur_q.wait_limit};
    diff = min_q - now;
    poll_res = cur_q.wait_limit;
    if (min_q != Never) begin
      if (cur_q.wait_limit[47] || (nw_sum > {1'b0, min_q})) begin
        if (min_q <= now) poll_res = '0;
        else if (diff > WaitMax) poll_res = WaitMax;
        else poll_res = diff;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.command)
            CMD_REMOVE, CMD_SET_EN, CMD_SET_IV, CMD_POLL:
              state_d = (count_q == '0) ? ST_DONE : ST_FIND;
            CMD_REM_ALL, CMD_DISPATCH:
              state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_FIND: begin
        if (match) state_d = (cur_q.command == CMD_REMOVE) ? ST_SHIFT : ST_DONE;
        else if (last_i) state_d = ST_DONE;
      end
      ST_SHIFT: state_d = ST_DONE;
      ST_SCAN: if (last_i) state_d = (best_ok_q || cand) ? ST_EMIT : ST_DONE;
      ST_EMIT: if (out_free) state_d = final_emit ? ST_IDLE : ST_SCAN;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  // Sequencer registers and table bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idc_q     <= '0;
      ov_q      <= 1'b0;
      taken_q   <= '0;
      i_q       <= '0;
      emitted_q <= '0;
      total_q   <= '0;
      best_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= emit_now ? 1'b1 : (ov_q && !res_out.ready);
      case (state_q)
        ST_IDLE: begin
          i_q <= '0; taken_q <= '0; emitted_q <= '0;
          best_ok_q <= 1'b0;
          // Remove all emits one result per entry; dispatch counts its due entries.
          total_q <= (q_data_i.command == CMD_REM_ALL) ? count_q : '0;
          if (q_valid_i && q_data_i.command == CMD_ADD && has_room) begin
            idc_q <= nid;
            count_q <= count_q + 1'b1;
          end
        end
        ST_FIND: if (!match && !last_i) i_q <= i_q + 1'b1;
        ST_SHIFT: count_q <= count_q - 1'b1;
        ST_SCAN: begin
          if (cand && better) best_ok_q <= 1'b1;
          if (emitted_q == '0 && cur_q.command == CMD_DISPATCH && cand) begin
            total_q <= total_q + 1'b1;
          end
          if (!last_i) i_q <= i_q + 1'b1;
        end
        ST_EMIT: if (out_free) begin
          taken_q[best_q] <= 1'b1;
          emitted_q <= emitted_q + 1'b1;
          best_ok_q <= 1'b0;
          i_q <= '0;
          if (final_emit && cur_q.command == CMD_REM_ALL) count_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers, pending result and table storage.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (q_valid_i) begin
        cur_q <= q_data_i;
        min_q <= Never;
        if (q_data_i.command == CMD_ADD && has_room) begin
          id_q[count_q[IdxBits-1:0]] <= nid;
          iv_q[count_q[IdxBits-1:0]] <= q_data_i.interval;
          dl_q[count_q[IdxBits-1:0]] <= q_data_i.enable ?
            sat_deadline(q_data_i.now_time, q_data_i.interval) : Never;
        end
        rs_kind_q <= (q_data_i.command == CMD_ADD) ? (has_room ? KIND_ADDED : KIND_FULL) :
                     (q_data_i.command == CMD_POLL) ? KIND_TIMEOUT : KIND_ACK;
        rs_id_q <= (q_data_i.command == CMD_ADD && has_room) ? nid : '0;
      end
      ST_FIND: begin
        if (dl_q[i_q] < min_q) min_q <= dl_q[i_q];
        if (match) begin
          fidx_q <= i_q;
          if (cur_q.command == CMD_SET_EN) begin
            dl_q[i_q] <= cur_q.enable ? sat_deadline(now, iv_q[i_q]) : Never;
          end else if (cur_q.command == CMD_SET_IV) begin
            iv_q[i_q] <= cur_q.interval;
          end else if (cur_q.command == CMD_REMOVE) begin
            rs_kind_q <= KIND_REMOVED;
            rs_id_q <= id_q[i_q];
          end
        end
      end
      ST_SHIFT: begin
        for (int k = 0; k < Timers - 1; k++) begin
          if (k[IdxBits-1:0] >= fidx_q) begin
            id_q[k] <= id_q[k+1]; iv_q[k] <= iv_q[k+1]; dl_q[k] <= dl_q[k+1];
          end
        end
      end
      ST_SCAN: if (cand && better) best_q <= i_q;
      ST_EMIT: if (out_free) begin
        od_q.kind <= (cur_q.command == CMD_REM_ALL) ? KIND_REMOVED : KIND_FIRED;
        od_q.result_id <= id_q[best_q];
        od_q.wait_ticks <= '0;
        od_q.last <= final_emit;
        if (cur_q.command == CMD_DISPATCH) begin
          dl_q[best_q] <= sat_deadline(now, iv_q[best_q]);
        end
      end
      ST_DONE: if (out_free) begin
        od_q.kind <= rs_kind_q;
        od_q.result_id <= rs_id_q;
        od_q.wait_ticks <= (cur_q.command == CMD_POLL) ? poll_res : '0;
        od_q.last <= 1'b1;
      end
      default: ;
    endcase
  end
endmodule

[rtl/core/periodic_timer_table.sv]
`timescale 1ns / 1ps
// Periodic timer table.
// One command channel (cmd_in) carries command, target_id, interval, enable,
// now_time and wait_limit; one result channel (res_out) carries kind,
// result_id, wait_ticks and last. Both use valid/ready; an item moves when
// both are high.
// A front end takes commands into a two-entry queue; a back-end sequencer
// works on one command at a time, walking the table one entry per cycle.
// A result passes the queue, the sequencer state and the output register
// before it is valid. Add and unknown commands need no table walk; remove,
// set enable and set interval search the table for the target id (remove
// then shifts the later entries down), and poll walks every entry. Dispatch
// and remove all walk the table once per result, one compare per entry, or
// once when no entry is due.
// A registered output stage holds each result; while the receiver stalls the
// sequencer waits, and the queue keeps taking commands until it is full.
// Reset empties the table and the queue and clears the id counter; table
// entries are not cleared.
module periodic_timer_table import ptt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptt_cmd_if.sink   cmd_in,
  ptt_res_if.source res_out
);
  logic q_valid, q_pop;
  cmd_t q_data;

  ptt_front u_front (
    .clk_i, .rst_ni, .cmd_in,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  ptt_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop), .res_out
  );
endmodule

[rtl/core/ptt_checker.sv]
`timescale 1ns / 1ps
`include "periodic_timer_table_defines.svh"
module ptt_checker import ptt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_data_i
);
  // A stalled result holds.
  `PTT_ASSERT(a_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i), "result changed while stalled")
  // Kinds beyond the timeout code never appear.
  `PTT_ASSERT(a_kind, clk_i, rst_ni, res_valid_i |-> res_data_i.kind <= KIND_TIMEOUT, "bad kind")
  // Only timeout results carry wait ticks.
  `PTT_ASSERT(a_wait, clk_i, rst_ni, res_valid_i && res_data_i.kind != KIND_TIMEOUT |-> res_data_i.wait_ticks == '0, "stray wait ticks")
  // No result is shown during reset.
  `PTT_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !res_valid_i, "result during reset")
endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk_i, .rst_ni,
  .res_valid_i(res_out.valid), .res_ready_i(res_out.ready), .res_data_i(res_out.data)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ptt_pkg::*;

  localparam int unsigned RandItems = 200;
  localparam int unsigned CycleLimit = 600000;
  localparam logic [47:0] IvMax = 48'hFFFF_FFFF_FFFE;

  logic clk_i;
  logic rst_ni;

  ptt_cmd_if cmd_if ();
  ptt_res_if res_if ();

  periodic_timer_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_in (cmd_if),
    .res_out(res_if)
  );

  // Shadow copy of the timer table.
  int unsigned  tbl_count;
  logic [31:0]  tbl_id [Timers];
  logic [47:0]  tbl_iv [Timers];
  logic [47:0]  tbl_dl [Timers];
  logic [31:0]  last_id;

  cmd_t pending_cmds [$];
  res_t awaited_res [$];
  int unsigned n_total;
  int unsigned n_accepted;
  int unsigned pause_at;
  int unsigned errors;
  int unsigned cycles;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned send_idle;
  int unsigned recv_idle;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [47:0] deadline_sum(logic [47:0] now, logic [47:0] iv);
    logic [48:0] s;
    s = {1'b0, now} + {1'b0, iv};
    return (s >= {1'b0, Never}) ? Never - 48'd1 : s[47:0];
  endfunction

  function automatic void push_res(kind_e k, logic [31:0] id, logic [47:0] w);
    res_t r;
    r.kind = k;
    r.result_id = id;
    r.wait_ticks = w;
    r.last = 1'b0;
    awaited_res.push_back(r);
  endfunction

  // Indices in (deadline, insertion) order; optionally only the due ones.
  function automatic int fire_order(ref int lst [Timers], input bit due_only,
                                    input logic [47:0] now);
    bit taken [Timers];
    int n;
    int best;
    n = 0;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int k = 0; k < tbl_count; k++) begin
      best = -1;
      for (int i = 0; i < tbl_count; i++) begin
        if (taken[i]) continue;
        if (due_only && !(tbl_dl[i] != Never && tbl_dl[i] <= now)) continue;
        if (best < 0 || tbl_dl[i] < tbl_dl[best]) best = i;
      end
      if (best < 0) break;
      taken[best] = 1'b1;
      lst[n++] = best;
    end
    return n;
  endfunction

  function automatic int find_timer(logic [31:0] id);
    for (int i = 0; i < tbl_count; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  // Work out the results of one accepted command and update the shadow table.
  function automatic void predict_timer_cmd(cmd_t c);
    int lst [Timers];
    int cnt;
    int idx;
    int n_prior;
    logic [47:0] nxt;
    logic [47:0] res;
    n_prior = awaited_res.size();
    case (cmd_e'(c.command))
      CMD_ADD: begin
        if (tbl_count >= Timers) begin
          push_res(KIND_FULL, '0, '0);
        end else begin
          last_id = last_id + 32'd1;
          if (last_id == 0) last_id = 32'd1;
          tbl_id[tbl_count] = last_id;
          tbl_iv[tbl_count] = c.interval;
          tbl_dl[tbl_count] = c.enable ? deadline_sum(c.now_time, c.interval) : Never;
          tbl_count++;
          push_res(KIND_ADDED, last_id, '0);
        end
      end
      CMD_REMOVE: begin
        idx = find_timer(c.target_id);
        if (idx < 0) begin
          push_res(KIND_ACK, '0, '0);
        end else begin
          push_res(KIND_REMOVED, tbl_id[idx], '0);
          for (int i = idx; i + 1 < tbl_count; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_iv[i] = tbl_iv[i+1];
            tbl_dl[i] = tbl_dl[i+1];
          end
          tbl_count--;
        end
      end
      CMD_REM_ALL: begin
        cnt = fire_order(lst, 1'b0, c.now_time);
        for (int k = cnt - 1; k >= 0; k--) push_res(KIND_REMOVED, tbl_id[lst[k]], '0);
        tbl_count = 0;
        if (cnt == 0) push_res(KIND_ACK, '0, '0);
      end
      CMD_SET_EN: begin
        idx = find_timer(c.target_id);
        if (idx >= 0) tbl_dl[idx] = c.enable ? deadline_sum(c.now_time, tbl_iv[idx]) : Never;
        push_res(KIND_ACK, '0, '0);
      end
      CMD_SET_IV: begin
        idx = find_timer(c.target_id);
        if (idx >= 0) tbl_iv[idx] = c.interval;
        push_res(KIND_ACK, '0, '0);
      end
      CMD_DISPATCH: begin
        cnt = fire_order(lst, 1'b1, c.now_time);
        for (int k = 0; k < cnt; k++) begin
          tbl_dl[lst[k]] = deadline_sum(c.now_time, tbl_iv[lst[k]]);
          push_res(KIND_FIRED, tbl_id[lst[k]], '0);
        end
        if (cnt == 0) push_res(KIND_ACK, '0, '0);
      end
      CMD_POLL: begin
        nxt = Never;
        res = c.wait_limit;
        for (int i = 0; i < tbl_count; i++) if (tbl_dl[i] < nxt) nxt = tbl_dl[i];
        if (nxt != Never) begin
          if (c.wait_limit[47] ||
              ({1'b0, c.now_time} + {1'b0, c.wait_limit}) > {1'b0, nxt}) begin
            res = (nxt <= c.now_time) ? 48'd0 : nxt - c.now_time;
            if (res > WaitMax) res = WaitMax;
          end
        end
        push_res(KIND_TIMEOUT, '0, res);
      end
      default: push_res(KIND_ACK, '0, '0);
    endcase
    awaited_res[awaited_res.size()-1].last = 1'b1;
    if (awaited_res.size() == n_prior) errors++;
  endfunction

  function automatic cmd_t make_cmd(cmd_e op, logic [31:0] id, logic [47:0] iv,
                                    bit en, logic [47:0] now, logic [47:0] wl);
    cmd_t c;
    c.command = op;
    c.target_id = id;
    c.interval = iv;
    c.enable = en;
    c.now_time = now;
    c.wait_limit = wl;
    return c;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
  endfunction

  // Stimulus: a directed opening, then random traffic biased towards live ids.
  initial begin
    logic [47:0] now_t;
    logic [47:0] iv;
    logic [47:0] wl;
    logic [31:0] id;
    int unsigned adds;
    int unsigned sel;
    cmd_e op;
    rst_ni = 1'b0;
    now_t = 48'd100;
    adds = 0;
    pending_cmds.push_back(make_cmd(CMD_REM_ALL, '0, '0, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_DISPATCH, '0, '0, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_POLL, '0, '0, 0, now_t, 48'hFFFF_FFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_POLL, '0, '0, 0, now_t, WaitMax));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, 48'd10, 1, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, 48'd0, 1, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, 48'd10, 1, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, IvMax, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, IvMax, 1, IvMax, '0));
    pending_cmds.push_back(make_cmd(CMD_POLL, '0, '0, 0, now_t, 48'hFFFF_FFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_POLL, '0, '0, 0, now_t, 48'd3));
    pending_cmds.push_back(make_cmd(CMD_DISPATCH, '0, '0, 0, now_t + 48'd10, '0));
    pending_cmds.push_back(make_cmd(CMD_SET_IV, 32'd4, 48'd7, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_SET_EN, 32'd4, '0, 1, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_SET_EN, 32'hFFFF_FFFF, '0, 1, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_SET_IV, 32'd0, IvMax, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_SET_EN, 32'd2, '0, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'hFFFF_FFFF, '0, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'd1, '0, 0, now_t, '0));
    pending_cmds.push_back(make_cmd(CMD_NONE, 32'hFFFF_FFFF, IvMax, 1, IvMax, WaitMax));
    pending_cmds.push_back(make_cmd(CMD_DISPATCH, '0, '0, 0, IvMax, '0));
    pending_cmds.push_back(make_cmd(CMD_REM_ALL, '0, '0, 0, now_t, '0));
    adds = 5;
    for (int n = 0; n < RandItems; n++) begin
      sel = $urandom_range(99);
      if (sel < 32) op = CMD_ADD;
      else if (sel < 46) op = CMD_REMOVE;
      else if (sel < 49) op = CMD_REM_ALL;
      else if (sel < 61) op = CMD_SET_EN;
      else if (sel < 69) op = CMD_SET_IV;
      else if (sel < 86) op = CMD_DISPATCH;
      else if (sel < 98) op = CMD_POLL;
      else op = CMD_NONE;
      if (op == CMD_ADD) adds++;
      now_t = now_t + $urandom_range(12);
      iv = ($urandom_range(9) == 0) ? rand48() : 48'($urandom_range(40));
      wl = ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(30));
      id = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(adds + 1);
      pending_cmds.push_back(make_cmd(op, id, iv, $urandom_range(3) != 0,
                                      ($urandom_range(24) == 0) ? rand48() : now_t, wl));
    end
    n_total = pending_cmds.size();
    pause_at = n_total / 2;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || cmd_if.valid || awaited_res.size() != 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Idle rates follow the phase of the run.
  always_comb begin
    if (n_accepted < n_total / 3) begin
      send_idle = 33;
      recv_idle = 48;
    end else if (n_accepted < 2 * n_total / 3) begin
      send_idle = 48;
      recv_idle = 33;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // Command driver: predicts each accepted item, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.data <= '0;
      n_accepted = 0;
      tbl_count = 0;
      last_id = '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_timer_cmd(cmd_if.data);
        n_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle &&
            !(n_accepted == pause_at && awaited_res.size() != 0)) begin
          cmd_if.valid <= 1'b1;
          cmd_if.data <= pending_cmds.pop_front();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off, counted in cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 30) begin
      hold_done <= 1'b1;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor with a random ready, held off during the long stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_res.size() == 0) begin
          $error("unexpected result: kind %0d id %0d", res_if.data.kind,
                 res_if.data.result_id);
          errors++;
        end else begin
          if (res_if.data.kind !== awaited_res[0].kind) begin
            $error("kind: expected %0d, got %0d", awaited_res[0].kind, res_if.data.kind);
            errors++;
          end
          if (res_if.data.result_id !== awaited_res[0].result_id) begin
            $error("result_id: expected %0d, got %0d", awaited_res[0].result_id,
                   res_if.data.result_id);
            errors++;
          end
          if (res_if.data.wait_ticks !== awaited_res[0].wait_ticks) begin
            $error("wait_ticks: expected %0h, got %0h", awaited_res[0].wait_ticks,
                   res_if.data.wait_ticks);
            errors++;
          end
          if (res_if.data.last !== awaited_res[0].last) begin
            $error("last: expected %0d, got %0d", awaited_res[0].last, res_if.data.last);
            errors++;
          end
          void'(awaited_res.pop_front());
        end
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ptt_pkg.sv
rtl/core/ptt_stream_if.sv
rtl/core/ptt_front.sv
rtl/core/ptt_back.sv
rtl/core/periodic_timer_table.sv
rtl/core/ptt_checker.sv
bench/testbench.sv
